// ===== src/limit_order_book_matcher_assert.svh =====
// Assertion macros for the order book matcher
`ifndef LIMIT_ORDER_BOOK_MATCHER_ASSERT_SVH
`define LIMIT_ORDER_BOOK_MATCHER_ASSERT_SVH
`ifndef SYNTHESIS
`define LOBM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("order book assertion failed");
`define LOBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("order book assertion failed");
`else
`define LOBM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LOBM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/lobm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_pkg
// Shared constants, types and helpers of the order book matcher.
// ----------------------------------------------------------------------------
package lobm_pkg;

	localparam int ORDER_IDS    = 64;
	localparam int PRICE_LEVELS = 256;
	localparam int IDW  = $clog2(ORDER_IDS);
	localparam int NIDW = $clog2(ORDER_IDS + 1);
	localparam int PW   = $clog2(PRICE_LEVELS);
	localparam int LVW  = PW + 1;
	localparam int LCW  = $clog2(PRICE_LEVELS + 1);
	localparam int QW   = 32;

	localparam logic [NIDW-1:0] NO_ID = NIDW'(ORDER_IDS);
	localparam logic SIDE_BUY  = 1'b0;
	localparam logic SIDE_SELL = 1'b1;

	typedef enum logic [1:0] {
		CMD_LIMIT, CMD_MARKET, CMD_CANCEL, CMD_MODIFY
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE, ST_TRADE, ST_UNKNOWN, ST_REJECT
	} status_t;

	typedef enum logic [1:0] {
		RET_FINISH, RET_SWEEP, RET_SCAN
	} rm_ret_t;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_LOOKUP, S_DECODE, S_RM_RD, S_RM_UPD, S_SW_INIT,
		S_SCAN_RD, S_SCAN_CK, S_FILL_RH, S_FILL_RT, S_FILL_CMP, S_FILL_UPD,
		S_SW_END, S_AP_RD, S_AP_UPD, S_AP_END, S_OUT_START, S_OUT_RD,
		S_OUT_LD, S_OUT_WAIT
	} state_t;

	typedef struct packed {
		logic [QW-1:0] qty;
		logic [PW-1:0] price;
		logic          side;
	} order_t;

	typedef struct packed {
		logic [IDW-1:0] buyer;
		logic [IDW-1:0] seller;
		logic [PW-1:0]  price;
		logic [QW-1:0]  qty;
	} trade_t;

	function automatic logic [LVW-1:0] lv_of(input logic side, input logic [PW-1:0] p);
		return side ? (LVW'(PRICE_LEVELS) + LVW'(p)) : LVW'(p);
	endfunction

endpackage

// ===== src/lobm_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_req_if
// Command channel: valid/ready with one order command per word.
// ----------------------------------------------------------------------------
interface lobm_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic        side;
	logic [5:0]  order_id;
	logic [7:0]  price;
	logic [31:0] quantity;

	modport source (output valid, cmd, side, order_id, price, quantity, input ready);
	modport sink (input valid, cmd, side, order_id, price, quantity, output ready);
endinterface

// ===== src/lobm_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_rsp_if
// Result channel: valid/ready with one trade or status per word.
// ----------------------------------------------------------------------------
interface lobm_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [5:0]  buyer_id;
	logic [5:0]  seller_id;
	logic [7:0]  trade_price;
	logic [31:0] trade_quantity;
	logic [6:0]  resting_count;
	logic [8:0]  bid_level_count;
	logic [8:0]  ask_level_count;
	logic        last;

	modport source (output valid, status, buyer_id, seller_id, trade_price,
		trade_quantity, resting_count, bid_level_count, ask_level_count, last,
		input ready);
	modport sink (input valid, status, buyer_id, seller_id, trade_price,
		trade_quantity, resting_count, bid_level_count, ask_level_count, last,
		output ready);
endinterface

// ===== src/lobm_trade_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_trade_buf
// Holds the trades of one command until the final book counts are known.
// ----------------------------------------------------------------------------
module lobm_trade_buf (
	input  logic                       clk,
	input  logic                       we,
	input  logic [lobm_pkg::IDW-1:0]   waddr,
	input  lobm_pkg::trade_t           wdata,
	input  logic [lobm_pkg::IDW-1:0]   raddr,
	output lobm_pkg::trade_t           rdata
);
	lobm_pkg::trade_t mem [lobm_pkg::ORDER_IDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== src/limit_order_book_matcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limit_order_book_matcher
// Price-time priority order book with a sequenced fill engine.
// ----------------------------------------------------------------------------
// Commands enter on req (limit, market, cancel, modify); results leave on rsp.
// A command is taken only when the block is idle; one command at a time.
// Each command yields one status word, or one trade word per fill with last
// on the final one. All words of a command carry the book counts after it.
// Steps: look up and decode; a sweep starts, scans the price levels for the
// best opposite level, takes each fill through head read, order read, compare
// and update, frees a resting order that a fill empties, and closes; a
// remainder is then appended. Output starts, then loads a status word, or
// reads and loads each trade word from the trade buffer.
// The level and order memories each have one read port and one write port.
// After reset the level occupancy memory is cleared, one entry a cycle, over
// all 2*PRICE_LEVELS entries (512); req.ready stays low meanwhile.
// Trades are buffered and replayed; when rsp.ready is low the current word
// holds and the block waits.
// ----------------------------------------------------------------------------
`include "limit_order_book_matcher_assert.svh"

module limit_order_book_matcher (
	input  logic        clk,
	input  logic        arst_n,
	lobm_req_if.sink    req,
	lobm_rsp_if.source  rsp
);
	localparam int IDW  = lobm_pkg::IDW;
	localparam int NIDW = lobm_pkg::NIDW;
	localparam int PW   = lobm_pkg::PW;
	localparam int LVW  = lobm_pkg::LVW;
	localparam int LCW  = lobm_pkg::LCW;
	localparam int QW   = lobm_pkg::QW;

	lobm_pkg::state_t state_q, state_d;

	// command registers
	lobm_pkg::cmd_t     cmd_q;
	logic               side_q;
	logic [IDW-1:0]     id_q;
	logic               idok_q;
	logic               pok_q;
	logic [PW-1:0]      price_q;
	logic [QW-1:0]      qty_q;
	lobm_pkg::status_t  status_q;

	// sweep and removal registers
	logic [PW-1:0]      sp_q;
	logic [LVW-1:0]     lv_q;
	logic [IDW-1:0]     r_q;
	logic [QW-1:0]      tq_q;
	lobm_pkg::order_t   ent_q;
	logic [IDW-1:0]     rid_q;
	lobm_pkg::rm_ret_t  ret_q;
	logic [NIDW-1:0]    cnt_q;
	logic [IDW-1:0]     oi_q;
	logic [LVW-1:0]     clr_q;

	// book status
	logic [lobm_pkg::ORDER_IDS-1:0] resting_q;
	logic [NIDW-1:0]    rest_tot_q;
	logic [LCW-1:0]     bid_q;
	logic [LCW-1:0]     ask_q;

	// memories
	lobm_pkg::order_t   ot_mem [lobm_pkg::ORDER_IDS];
	logic [NIDW-1:0]    pv_mem [lobm_pkg::ORDER_IDS];
	logic [NIDW-1:0]    nx_mem [lobm_pkg::ORDER_IDS];
	logic [IDW-1:0]     hd_mem [2*lobm_pkg::PRICE_LEVELS];
	logic [IDW-1:0]     tl_mem [2*lobm_pkg::PRICE_LEVELS];
	logic               oc_mem [2*lobm_pkg::PRICE_LEVELS];

	lobm_pkg::order_t   ot_rd_q, ot_wd;
	logic [NIDW-1:0]    pv_rd_q, nx_rd_q, pv_wd, nx_wd;
	logic [IDW-1:0]     hd_rd_q, tl_rd_q, hd_wd, tl_wd;
	logic               oc_rd_q, oc_wd;
	logic [IDW-1:0]     ot_ra, pv_ra, ot_wa, pv_wa, nx_wa;
	logic [LVW-1:0]     hd_ra, tl_ra, oc_ra, hd_wa, tl_wa, oc_wa;
	logic               ot_we, pv_we, nx_we, hd_we, tl_we, oc_we;

	lobm_pkg::trade_t   buf_wd, buf_rd;
	logic               buf_we;

	// output register
	logic               out_valid_q;
	lobm_pkg::status_t  out_status_q;
	logic [IDW-1:0]     out_buyer_q, out_seller_q;
	logic [PW-1:0]      out_price_q;
	logic [QW-1:0]      out_qty_q;
	logic               out_last_q;
	logic               load_status, load_trade;

	// combinational helpers
	logic               accept;
	logic               out_take;
	logic [LVW-1:0]     rm_lv, ap_lv;
	logic               rm_empty;
	logic [QW-1:0]      newq;
	logic               res_hit;

	assign accept   = req.valid && req.ready;
	assign out_take = out_valid_q && rsp.ready;
	assign rm_lv    = lobm_pkg::lv_of(ot_rd_q.side, ot_rd_q.price);
	assign ap_lv    = lobm_pkg::lv_of(side_q, price_q);
	assign rm_empty = (pv_rd_q == lobm_pkg::NO_ID) && (nx_rd_q == lobm_pkg::NO_ID);
	assign newq     = ent_q.qty - tq_q;
	assign res_hit  = idok_q && resting_q[id_q];

	// memory ports
	always_ff @(posedge clk) begin
		if (ot_we) begin
			ot_mem[ot_wa] <= ot_wd;
		end
		ot_rd_q <= ot_mem[ot_ra];
	end

	always_ff @(posedge clk) begin
		if (pv_we) begin
			pv_mem[pv_wa] <= pv_wd;
		end
		pv_rd_q <= pv_mem[pv_ra];
	end

	always_ff @(posedge clk) begin
		if (nx_we) begin
			nx_mem[nx_wa] <= nx_wd;
		end
		nx_rd_q <= nx_mem[pv_ra];
	end

	always_ff @(posedge clk) begin
		if (hd_we) begin
			hd_mem[hd_wa] <= hd_wd;
		end
		hd_rd_q <= hd_mem[hd_ra];
	end

	always_ff @(posedge clk) begin
		if (tl_we) begin
			tl_mem[tl_wa] <= tl_wd;
		end
		tl_rd_q <= tl_mem[tl_ra];
	end

	always_ff @(posedge clk) begin
		if (oc_we) begin
			oc_mem[oc_wa] <= oc_wd;
		end
		oc_rd_q <= oc_mem[oc_ra];
	end

	lobm_trade_buf u_trade_buf (
		.clk   (clk),
		.we    (buf_we),
		.waddr (cnt_q[IDW-1:0]),
		.wdata (buf_wd),
		.raddr (oi_q),
		.rdata (buf_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lobm_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, memory addresses and write strobes
	always_comb begin
		state_d = state_q;
		ot_ra = id_q;    pv_ra = rid_q;
		hd_ra = lv_q;    tl_ra = ap_lv;   oc_ra = ap_lv;
		ot_we = 1'b0;    ot_wa = id_q;    ot_wd = '0;
		pv_we = 1'b0;    pv_wa = id_q;    pv_wd = lobm_pkg::NO_ID;
		nx_we = 1'b0;    nx_wa = id_q;    nx_wd = lobm_pkg::NO_ID;
		hd_we = 1'b0;    hd_wa = ap_lv;   hd_wd = id_q;
		tl_we = 1'b0;    tl_wa = ap_lv;   tl_wd = id_q;
		oc_we = 1'b0;    oc_wa = ap_lv;   oc_wd = 1'b0;
		buf_we = 1'b0;
		buf_wd = '0;
		load_status = 1'b0;
		load_trade  = 1'b0;
		case (state_q)
			lobm_pkg::S_CLEAR: begin
				oc_we = 1'b1;
				oc_wa = clr_q;
				if (clr_q == LVW'(2*lobm_pkg::PRICE_LEVELS - 1)) begin
					state_d = lobm_pkg::S_IDLE;
				end
			end
			lobm_pkg::S_IDLE: begin
				if (accept) begin
					state_d = lobm_pkg::S_LOOKUP;
				end
			end
			lobm_pkg::S_LOOKUP: begin
				state_d = lobm_pkg::S_DECODE;
			end
			lobm_pkg::S_DECODE: begin
				case (cmd_q)
					lobm_pkg::CMD_LIMIT, lobm_pkg::CMD_MARKET: begin
						if (!idok_q || res_hit || qty_q == '0 ||
							(cmd_q == lobm_pkg::CMD_LIMIT && !pok_q)) begin
							state_d = lobm_pkg::S_OUT_START;
						end else begin
							state_d = lobm_pkg::S_SW_INIT;
						end
					end
					lobm_pkg::CMD_CANCEL: begin
						state_d = res_hit ? lobm_pkg::S_RM_RD : lobm_pkg::S_OUT_START;
					end
					default: begin
						if (res_hit && qty_q != '0 && pok_q) begin
							state_d = lobm_pkg::S_RM_RD;
						end else begin
							state_d = lobm_pkg::S_OUT_START;
						end
					end
				endcase
			end
			lobm_pkg::S_RM_RD: begin
				ot_ra = rid_q;
				state_d = lobm_pkg::S_RM_UPD;
			end
			lobm_pkg::S_RM_UPD: begin
				// unlink from the level FIFO; drop the level when it empties
				if (pv_rd_q != lobm_pkg::NO_ID) begin
					nx_we = 1'b1;
					nx_wa = pv_rd_q[IDW-1:0];
					nx_wd = nx_rd_q;
				end else begin
					hd_we = 1'b1;
					hd_wa = rm_lv;
					hd_wd = nx_rd_q[IDW-1:0];
				end
				if (nx_rd_q != lobm_pkg::NO_ID) begin
					pv_we = 1'b1;
					pv_wa = nx_rd_q[IDW-1:0];
					pv_wd = pv_rd_q;
				end else begin
					tl_we = 1'b1;
					tl_wa = rm_lv;
					tl_wd = pv_rd_q[IDW-1:0];
				end
				if (rm_empty) begin
					oc_we = 1'b1;
					oc_wa = rm_lv;
					oc_wd = 1'b0;
				end
				case (ret_q)
					lobm_pkg::RET_SWEEP: state_d = lobm_pkg::S_SW_INIT;
					lobm_pkg::RET_SCAN:  state_d = lobm_pkg::S_SCAN_RD;
					default:             state_d = lobm_pkg::S_OUT_START;
				endcase
			end
			lobm_pkg::S_SW_INIT: begin
				state_d = lobm_pkg::S_SCAN_RD;
			end
			lobm_pkg::S_SCAN_RD: begin
				oc_ra = lobm_pkg::lv_of(!side_q, sp_q);
				state_d = (qty_q == '0) ? lobm_pkg::S_SW_END : lobm_pkg::S_SCAN_CK;
			end
			lobm_pkg::S_SCAN_CK: begin
				if (oc_rd_q) begin
					state_d = lobm_pkg::S_FILL_RH;
				end else if (sp_q == price_q) begin
					state_d = lobm_pkg::S_SW_END;
				end else begin
					state_d = lobm_pkg::S_SCAN_RD;
				end
			end
			lobm_pkg::S_FILL_RH: begin
				hd_ra = lv_q;
				state_d = lobm_pkg::S_FILL_RT;
			end
			lobm_pkg::S_FILL_RT: begin
				ot_ra = hd_rd_q;
				state_d = lobm_pkg::S_FILL_CMP;
			end
			lobm_pkg::S_FILL_CMP: begin
				state_d = lobm_pkg::S_FILL_UPD;
			end
			lobm_pkg::S_FILL_UPD: begin
				ot_we = 1'b1;
				ot_wa = r_q;
				ot_wd = '{qty: newq, price: ent_q.price, side: ent_q.side};
				buf_we = 1'b1;
				buf_wd.buyer  = (side_q == lobm_pkg::SIDE_BUY) ? id_q : r_q;
				buf_wd.seller = (side_q == lobm_pkg::SIDE_BUY) ? r_q : id_q;
				buf_wd.price  = ent_q.price;
				buf_wd.qty    = tq_q;
				state_d = (newq == '0) ? lobm_pkg::S_RM_RD : lobm_pkg::S_SCAN_RD;
			end
			lobm_pkg::S_SW_END: begin
				if (cmd_q != lobm_pkg::CMD_MARKET && qty_q != '0) begin
					state_d = lobm_pkg::S_AP_RD;
				end else begin
					state_d = lobm_pkg::S_OUT_START;
				end
			end
			lobm_pkg::S_AP_RD: begin
				state_d = lobm_pkg::S_AP_UPD;
			end
			lobm_pkg::S_AP_UPD: begin
				ot_we = 1'b1;
				ot_wa = id_q;
				ot_wd = '{qty: qty_q, price: price_q, side: side_q};
				pv_we = 1'b1;
				pv_wa = id_q;
				tl_we = 1'b1;
				if (oc_rd_q) begin
					pv_wd = NIDW'(tl_rd_q);
					nx_we = 1'b1;
					nx_wa = tl_rd_q;
					nx_wd = NIDW'(id_q);
				end else begin
					pv_wd = lobm_pkg::NO_ID;
					hd_we = 1'b1;
					oc_we = 1'b1;
					oc_wd = 1'b1;
				end
				state_d = lobm_pkg::S_AP_END;
			end
			lobm_pkg::S_AP_END: begin
				nx_we = 1'b1;
				nx_wa = id_q;
				nx_wd = lobm_pkg::NO_ID;
				state_d = lobm_pkg::S_OUT_START;
			end
			lobm_pkg::S_OUT_START: begin
				if (cnt_q == '0) begin
					load_status = 1'b1;
					state_d = lobm_pkg::S_OUT_WAIT;
				end else begin
					state_d = lobm_pkg::S_OUT_RD;
				end
			end
			lobm_pkg::S_OUT_RD: begin
				state_d = lobm_pkg::S_OUT_LD;
			end
			lobm_pkg::S_OUT_LD: begin
				load_trade = 1'b1;
				state_d = lobm_pkg::S_OUT_WAIT;
			end
			lobm_pkg::S_OUT_WAIT: begin
				if (out_take) begin
					state_d = out_last_q ? lobm_pkg::S_IDLE : lobm_pkg::S_OUT_RD;
				end
			end
			default: begin
				state_d = lobm_pkg::S_IDLE;
			end
		endcase
	end

	// control and book counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			resting_q  <= '0;
			rest_tot_q <= '0;
			bid_q      <= '0;
			ask_q      <= '0;
			cnt_q      <= '0;
			oi_q       <= '0;
			ret_q      <= lobm_pkg::RET_FINISH;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				lobm_pkg::S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
				end
				lobm_pkg::S_IDLE: begin
					cnt_q <= '0;
					oi_q  <= '0;
				end
				lobm_pkg::S_DECODE: begin
					ret_q <= (cmd_q == lobm_pkg::CMD_CANCEL) ?
						lobm_pkg::RET_FINISH : lobm_pkg::RET_SWEEP;
				end
				lobm_pkg::S_RM_UPD: begin
					resting_q[rid_q] <= 1'b0;
					rest_tot_q <= rest_tot_q - 1'b1;
					if (rm_empty) begin
						if (ot_rd_q.side == lobm_pkg::SIDE_BUY) begin
							bid_q <= bid_q - 1'b1;
						end else begin
							ask_q <= ask_q - 1'b1;
						end
					end
				end
				lobm_pkg::S_FILL_UPD: begin
					cnt_q <= cnt_q + 1'b1;
					ret_q <= lobm_pkg::RET_SCAN;
				end
				lobm_pkg::S_AP_UPD: begin
					resting_q[id_q] <= 1'b1;
					rest_tot_q <= rest_tot_q + 1'b1;
					if (!oc_rd_q) begin
						if (side_q == lobm_pkg::SIDE_BUY) begin
							bid_q <= bid_q + 1'b1;
						end else begin
							ask_q <= ask_q + 1'b1;
						end
					end
				end
				lobm_pkg::S_OUT_WAIT: begin
					if (out_take) begin
						oi_q <= oi_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
			if (load_status || load_trade) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			lobm_pkg::S_IDLE: begin
				cmd_q    <= lobm_pkg::cmd_t'(req.cmd);
				side_q   <= req.side;
				id_q     <= req.order_id[IDW-1:0];
				idok_q   <= 32'(req.order_id) < lobm_pkg::ORDER_IDS;
				pok_q    <= 32'(req.price) < lobm_pkg::PRICE_LEVELS;
				price_q  <= PW'(req.price);
				qty_q    <= req.quantity;
				status_q <= lobm_pkg::ST_DONE;
			end
			lobm_pkg::S_DECODE: begin
				rid_q <= id_q;
				case (cmd_q)
					lobm_pkg::CMD_LIMIT, lobm_pkg::CMD_MARKET: begin
						if (!idok_q || res_hit || qty_q == '0 ||
							(cmd_q == lobm_pkg::CMD_LIMIT && !pok_q)) begin
							status_q <= lobm_pkg::ST_REJECT;
						end
						if (cmd_q == lobm_pkg::CMD_MARKET) begin
							price_q <= (side_q == lobm_pkg::SIDE_BUY) ?
								PW'(lobm_pkg::PRICE_LEVELS - 1) : '0;
						end
					end
					lobm_pkg::CMD_CANCEL: begin
						if (!res_hit) begin
							status_q <= lobm_pkg::ST_UNKNOWN;
						end
					end
					default: begin
						if (!res_hit) begin
							status_q <= lobm_pkg::ST_UNKNOWN;
						end else if (qty_q == '0 || !pok_q) begin
							status_q <= lobm_pkg::ST_REJECT;
						end
						side_q <= ot_rd_q.side;
					end
				endcase
			end
			lobm_pkg::S_SW_INIT: begin
				sp_q <= (side_q == lobm_pkg::SIDE_BUY) ?
					'0 : PW'(lobm_pkg::PRICE_LEVELS - 1);
			end
			lobm_pkg::S_SCAN_CK: begin
				// keep the pointer on a hit; emptied levels never refill mid-sweep
				if (oc_rd_q) begin
					lv_q <= lobm_pkg::lv_of(!side_q, sp_q);
				end else if (sp_q != price_q) begin
					sp_q <= (side_q == lobm_pkg::SIDE_BUY) ? sp_q + 1'b1 : sp_q - 1'b1;
				end
			end
			lobm_pkg::S_FILL_RT: begin
				r_q <= hd_rd_q;
			end
			lobm_pkg::S_FILL_CMP: begin
				tq_q  <= (ot_rd_q.qty < qty_q) ? ot_rd_q.qty : qty_q;
				ent_q <= ot_rd_q;
			end
			lobm_pkg::S_FILL_UPD: begin
				qty_q <= qty_q - tq_q;
				rid_q <= r_q;
			end
			default: begin
			end
		endcase
		if (load_status) begin
			out_status_q <= status_q;
			out_buyer_q  <= '0;
			out_seller_q <= '0;
			out_price_q  <= '0;
			out_qty_q    <= '0;
			out_last_q   <= 1'b1;
		end else if (load_trade) begin
			out_status_q <= lobm_pkg::ST_TRADE;
			out_buyer_q  <= buf_rd.buyer;
			out_seller_q <= buf_rd.seller;
			out_price_q  <= buf_rd.price;
			out_qty_q    <= buf_rd.qty;
			out_last_q   <= (NIDW'(oi_q) + 1'b1) == cnt_q;
		end
	end

	assign req.ready           = (state_q == lobm_pkg::S_IDLE);
	assign rsp.valid           = out_valid_q;
	assign rsp.status          = out_status_q;
	assign rsp.buyer_id        = 6'(out_buyer_q);
	assign rsp.seller_id       = 6'(out_seller_q);
	assign rsp.trade_price     = 8'(out_price_q);
	assign rsp.trade_quantity  = out_qty_q;
	assign rsp.resting_count   = 7'(rest_tot_q);
	assign rsp.bid_level_count = 9'(bid_q);
	assign rsp.ask_level_count = 9'(ask_q);
	assign rsp.last            = out_last_q;

	`LOBM_ASSERT_IMPL(a_idle_no_word, clk, arst_n, req.ready, !rsp.valid)
	`LOBM_ASSERT_NEXT(a_busy_after_take, clk, arst_n, accept, !req.ready)
	`LOBM_ASSERT_IMPL(a_rest_bound, clk, arst_n, 1'b1, rest_tot_q <= NIDW'(lobm_pkg::ORDER_IDS))
	`LOBM_ASSERT_IMPL(a_trade_has_fill, clk, arst_n, rsp.valid && rsp.status == lobm_pkg::ST_TRADE, cnt_q != '0)

endmodule

// ===== tb/lobm_book_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_book_checker
// Watches the command and result channels of the order book matcher. Keeps
// its own copy of the book, works out the trade and status words that each
// accepted command must give, and compares every result word in order.
// ----------------------------------------------------------------------------
module lobm_book_checker (
	input  logic        clk,
	input  logic        arst_n,
	lobm_req_if         req,
	lobm_rsp_if         rsp,
	output int          fail_count,
	output int          words_pending
);
	localparam int IDS       = lobm_pkg::ORDER_IDS;
	localparam int LVLS      = lobm_pkg::PRICE_LEVELS;
	localparam int EXP_DEPTH = 128;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  buyer;
		logic [5:0]  seller;
		logic [7:0]  price;
		logic [31:0] qty;
		logic [6:0]  resting;
		logic [8:0]  bids;
		logic [8:0]  asks;
		logic        last;
	} book_word_t;

	// expected words in a ring, trades of the current command in a flat list
	book_word_t exp_words[EXP_DEPTH];
	int          exp_wr, exp_rd;
	book_word_t trades[IDS];
	int          n_trades;

	logic [31:0] ord_qty  [IDS];
	logic [7:0]  ord_price[IDS];
	logic        ord_side [IDS];
	logic        ord_live [IDS];
	int          link_prev[IDS];
	int          link_next[IDS];
	int          lvl_head [2*LVLS];
	int          lvl_tail [2*LVLS];
	logic        lvl_used [2*LVLS];
	int          n_resting, n_bids, n_asks;

	task automatic book_clear();
		for (int i = 0; i < IDS; i++) begin
			ord_live[i] = 1'b0;
			ord_qty[i] = '0;
			ord_price[i] = '0;
			ord_side[i] = 1'b0;
		end
		for (int i = 0; i < 2*LVLS; i++) begin
			lvl_used[i] = 1'b0;
			lvl_head[i] = IDS;
			lvl_tail[i] = IDS;
		end
		n_resting = 0;
		n_bids = 0;
		n_asks = 0;
	endtask

	task automatic level_delta(input logic s, input int d);
		if (s == lobm_pkg::SIDE_BUY) begin
			n_bids += d;
		end else begin
			n_asks += d;
		end
	endtask

	task automatic rest_order(input int id, input logic s, input int p, input logic [31:0] q);
		int lv;
		lv = int'(s) * LVLS + p;
		ord_qty[id] = q;
		ord_price[id] = 8'(p);
		ord_side[id] = s;
		ord_live[id] = 1'b1;
		link_next[id] = IDS;
		if (lvl_used[lv]) begin
			link_prev[id] = lvl_tail[lv];
			link_next[lvl_tail[lv]] = id;
			lvl_tail[lv] = id;
		end else begin
			link_prev[id] = IDS;
			lvl_head[lv] = id;
			lvl_tail[lv] = id;
			lvl_used[lv] = 1'b1;
			level_delta(s, 1);
		end
		n_resting++;
	endtask

	task automatic unlink_order(input int id);
		int lv, p, n;
		lv = int'(ord_side[id]) * LVLS + int'(ord_price[id]);
		p = link_prev[id];
		n = link_next[id];
		if (p != IDS) begin
			link_next[p] = n;
		end else begin
			lvl_head[lv] = n;
		end
		if (n != IDS) begin
			link_prev[n] = p;
		end else begin
			lvl_tail[lv] = p;
		end
		if (lvl_head[lv] == IDS) begin
			lvl_used[lv] = 1'b0;
			level_delta(ord_side[id], -1);
		end
		ord_live[id] = 1'b0;
		n_resting--;
	endtask

	// Fill against the best opposite levels while the limit still crosses.
	task automatic match_sweep(input int id, input logic s, input int lim,
			inout logic [31:0] q);
		int lv, r;
		logic hit;
		logic [31:0] fq;
		book_word_t w;
		while (q != 0) begin
			hit = 1'b0;
			lv = 0;
			if (s == lobm_pkg::SIDE_BUY) begin
				for (int p = 0; p <= lim && p < LVLS; p++) begin
					if (!hit && lvl_used[LVLS + p]) begin
						lv = LVLS + p;
						hit = 1'b1;
					end
				end
			end else begin
				for (int p = LVLS; p > lim; p--) begin
					if (!hit && lvl_used[p - 1]) begin
						lv = p - 1;
						hit = 1'b1;
					end
				end
			end
			if (!hit || n_trades >= IDS) break;
			r = lvl_head[lv];
			fq = (ord_qty[r] < q) ? ord_qty[r] : q;
			q -= fq;
			ord_qty[r] -= fq;
			w = '0;
			w.status = lobm_pkg::ST_TRADE;
			w.buyer = 6'((s == lobm_pkg::SIDE_BUY) ? id : r);
			w.seller = 6'((s == lobm_pkg::SIDE_BUY) ? r : id);
			w.price = ord_price[r];
			w.qty = fq;
			trades[n_trades] = w;
			n_trades++;
			if (ord_qty[r] == 0) unlink_order(r);
		end
	endtask

	task automatic store_expected(input book_word_t w);
		if (exp_wr - exp_rd >= EXP_DEPTH) begin
			fail_count++;
			$display("%0t: too many result words outstanding, expected %h dropped",
				$time, w);
		end else begin
			exp_words[exp_wr % EXP_DEPTH] = w;
			exp_wr++;
		end
	endtask

	task automatic predict_command(input logic [1:0] c, input logic s, input int id,
			input int p, input logic [31:0] q);
		lobm_pkg::status_t st;
		logic sd;
		book_word_t w;
		st = lobm_pkg::ST_DONE;
		sd = s;
		n_trades = 0;
		if (c == lobm_pkg::CMD_LIMIT || c == lobm_pkg::CMD_MARKET) begin
			if (ord_live[id] || q == 0) begin
				st = lobm_pkg::ST_REJECT;
			end else if (c == lobm_pkg::CMD_LIMIT) begin
				match_sweep(id, sd, p, q);
				if (q != 0) rest_order(id, sd, p, q);
			end else begin
				match_sweep(id, sd, (sd == lobm_pkg::SIDE_BUY) ? LVLS - 1 : 0, q);
			end
		end else if (!ord_live[id]) begin
			st = lobm_pkg::ST_UNKNOWN;
		end else if (c == lobm_pkg::CMD_CANCEL) begin
			unlink_order(id);
		end else if (q == 0) begin
			st = lobm_pkg::ST_REJECT;
		end else begin
			sd = ord_side[id];
			unlink_order(id);
			match_sweep(id, sd, p, q);
			if (q != 0) rest_order(id, sd, p, q);
		end
		if (n_trades == 0) begin
			w = '0;
			w.status = st;
			trades[0] = w;
			n_trades = 1;
		end
		for (int k = 0; k < n_trades; k++) begin
			w = trades[k];
			w.resting = 7'(n_resting);
			w.bids = 9'(n_bids);
			w.asks = 9'(n_asks);
			w.last = (k == n_trades - 1);
			store_expected(w);
		end
	endtask

	initial begin
		fail_count = 0;
		exp_wr = 0;
		exp_rd = 0;
		n_trades = 0;
		book_clear();
	end

	assign words_pending = exp_wr - exp_rd;

	always @(posedge clk) begin
		book_word_t got, want;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				got = {rsp.status, rsp.buyer_id, rsp.seller_id, rsp.trade_price,
					rsp.trade_quantity, rsp.resting_count, rsp.bid_level_count,
					rsp.ask_level_count, rsp.last};
				if (exp_wr == exp_rd) begin
					fail_count++;
					$display("%0t: unexpected result word %h", $time, got);
				end else begin
					want = exp_words[exp_rd % EXP_DEPTH];
					exp_rd++;
					if (got !== want) begin
						fail_count++;
						$display({"%0t: mismatch expected st=%0d b=%0d s=%0d p=%0d",
							" q=%0d r=%0d bl=%0d al=%0d l=%0b"},
							$time, want.status, want.buyer, want.seller, want.price,
							want.qty, want.resting, want.bids, want.asks, want.last);
						$display({"%0t:          actual   st=%0d b=%0d s=%0d p=%0d",
							" q=%0d r=%0d bl=%0d al=%0d l=%0b"},
							$time, got.status, got.buyer, got.seller, got.price,
							got.qty, got.resting, got.bids, got.asks, got.last);
					end
				end
			end
			if (req.valid && req.ready) begin
				predict_command(req.cmd, req.side, int'(req.order_id), int'(req.price),
					req.quantity);
			end
		end
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the order book matcher: a directed opening, then
// random limit, market, cancel and modify commands with random gaps on both
// channels and one long result stall. The checker does the comparing.
// ----------------------------------------------------------------------------
module tb;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   words_pending;
	logic sending_done;

	lobm_req_if req();
	lobm_rsp_if rsp();

	limit_order_book_matcher u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	lobm_book_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req),
		.rsp           (rsp),
		.fail_count    (fail_count),
		.words_pending (words_pending)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic int gap_len();
		int r;
		r = int'($urandom_range(0, 99));
		if (r < 40) return 0;
		if (r < 90) return int'($urandom_range(1, 3));
		return int'($urandom_range(10, 60));
	endfunction

	task automatic send_word(input lobm_pkg::cmd_t c, input logic s, input int id,
			input int p, input logic [31:0] q);
		int g;
		req.valid <= 1'b1;
		req.cmd <= c;
		req.side <= s;
		req.order_id <= 6'(id);
		req.price <= 8'(p);
		req.quantity <= q;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		@(negedge clk);
		g = gap_len();
		if (g != 0 && $urandom_range(0, 2) != 0) begin
			req.valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
	endtask

	function automatic logic [31:0] rand_qty();
		int r;
		r = int'($urandom_range(0, 99));
		if (r < 3) return '0;
		if (r < 8) return $urandom();
		if (r < 10) return 32'hFFFF_FFFF;
		return $urandom_range(1, 60);
	endfunction

	function automatic int rand_price();
		int r;
		r = int'($urandom_range(0, 99));
		if (r < 4) return 0;
		if (r < 8) return 255;
		if (r < 12) return int'($urandom_range(0, 255));
		return int'($urandom_range(118, 134));
	endfunction

	initial begin
		int r;
		lobm_pkg::cmd_t c;
		arst_n = 1'b0;
		sending_done = 1'b0;
		req.valid = 1'b0;
		req.cmd = lobm_pkg::CMD_LIMIT;
		req.side = lobm_pkg::SIDE_BUY;
		req.order_id = '0;
		req.price = '0;
		req.quantity = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_word(lobm_pkg::CMD_LIMIT, lobm_pkg::SIDE_BUY, 0, 0, 32'hFFFF_FFFF);
		send_word(lobm_pkg::CMD_LIMIT, lobm_pkg::SIDE_SELL, 63, 255, 1);
		send_word(lobm_pkg::CMD_LIMIT, lobm_pkg::SIDE_SELL, 1, 255, 7);
		send_word(lobm_pkg::CMD_LIMIT, lobm_pkg::SIDE_SELL, 2, 0, 5);
		send_word(lobm_pkg::CMD_LIMIT, lobm_pkg::SIDE_BUY, 0, 10, 3);
		send_word(lobm_pkg::CMD_LIMIT, lobm_pkg::SIDE_BUY, 3, 0, 0);
		send_word(lobm_pkg::CMD_MARKET, lobm_pkg::SIDE_SELL, 4, 77, 0);
		send_word(lobm_pkg::CMD_CANCEL, lobm_pkg::SIDE_BUY, 5, 0, 0);
		send_word(lobm_pkg::CMD_MODIFY, lobm_pkg::SIDE_SELL, 6, 9, 9);
		send_word(lobm_pkg::CMD_MODIFY, lobm_pkg::SIDE_BUY, 63, 200, 0);
		send_word(lobm_pkg::CMD_MODIFY, lobm_pkg::SIDE_BUY, 63, 254, 4);
		send_word(lobm_pkg::CMD_MARKET, lobm_pkg::SIDE_BUY, 7, 0, 32'hFFFF_FFFF);
		send_word(lobm_pkg::CMD_MODIFY, lobm_pkg::SIDE_BUY, 0, 255, 32'h8000_0000);
		send_word(lobm_pkg::CMD_LIMIT, lobm_pkg::SIDE_SELL, 8, 255, 2);
		send_word(lobm_pkg::CMD_LIMIT, lobm_pkg::SIDE_SELL, 9, 128, 32'h7FFF_FFFF);
		send_word(lobm_pkg::CMD_MARKET, lobm_pkg::SIDE_SELL, 10, 0, 32'hFFFF_FFFF);
		send_word(lobm_pkg::CMD_CANCEL, lobm_pkg::SIDE_SELL, 9, 255, 1);
		send_word(lobm_pkg::CMD_CANCEL, lobm_pkg::SIDE_SELL, 9, 0, 0);

		repeat (320) begin
			r = int'($urandom_range(0, 99));
			c = (r < 55) ? lobm_pkg::CMD_LIMIT : (r < 65) ? lobm_pkg::CMD_MARKET :
				(r < 82) ? lobm_pkg::CMD_CANCEL : lobm_pkg::CMD_MODIFY;
			send_word(c, 1'($urandom_range(0, 1)), int'($urandom_range(0, 63)),
				rand_price(),
				(c == lobm_pkg::CMD_MARKET && $urandom_range(0, 3) != 0) ?
				32'($urandom_range(1, 40)) : rand_qty());
		end
		req.valid <= 1'b0;
		sending_done = 1'b1;
	end

	// Result side: random stalls, with one long hold that also holds off new commands.
	initial begin
		int n;
		int g;
		rsp.ready = 1'b0;
		n = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			n++;
			if (n == 700) begin
				rsp.ready <= 1'b0;
				repeat (400) @(negedge clk);
			end
			g = gap_len();
			if (n > 2000 && n < 2600) begin
				rsp.ready <= 1'b1;
			end else if ($urandom_range(0, 3) == 0 && g != 0) begin
				rsp.ready <= 1'b0;
				repeat (g) @(negedge clk);
				rsp.ready <= 1'b1;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	initial begin
		wait (sending_done);
		wait (words_pending == 0);
		repeat (300) @(posedge clk);
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#200ms;
		$display("Verification failed");
		$finish;
	end

endmodule
